@@ design/ifgp_pkg.sv @@
// shared types and constants for the imu frame group parser
// no dependencies

package ifgp_pkg;

  localparam int FRAMES_PER_GROUP = 4;
  localparam int FIDX_W = (FRAMES_PER_GROUP > 1) ? $clog2(FRAMES_PER_GROUP) : 1;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] GROUP_TYPE = 8'h51;
  localparam logic [7:0] TYPE_MASK  = 8'h50;
  localparam logic [7:0] GROUP_SUM  = 8'hA6;
  localparam logic [3:0] CHECK_POS  = 4'd10;
  localparam int         DATA_LANES = 6;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_GROUP  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]         frame_type;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic               frame_status;
    logic               last_of_group;
  } result_t;

endpackage

@@ design/ifgp_parser.sv @@
// per-byte frame parser: sync phase, frame counters, checksum and field capture
// depends on ifgp_pkg

module ifgp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_vld,
  input  logic [7:0]       byte_in,
  output logic             res_push,
  output ifgp_pkg::result_t res
);

  ifgp_pkg::phase_t             phase_r, phase_nxt;
  logic [3:0]                   pos_r, pos_nxt;
  logic [ifgp_pkg::FIDX_W-1:0]  fidx_r, fidx_nxt;
  logic [7:0]                   sum_r, sum_nxt;
  logic                         hdr_ok_r, hdr_ok_nxt;
  logic [7:0]                   type_r, type_nxt;
  logic [47:0]                  data_r, data_nxt;
  logic                         abort_r, abort_nxt;
  logic                         frame_ok;
  logic                         last_frame;
  logic                         close_frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ifgp_pkg::PH_HUNT;
      pos_r    <= '0;
      fidx_r   <= '0;
      sum_r    <= '0;
      hdr_ok_r <= 1'b0;
      type_r   <= '0;
      data_r   <= '0;
      abort_r  <= 1'b0;
    end else if (byte_vld) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      fidx_r   <= fidx_nxt;
      sum_r    <= sum_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      type_r   <= type_nxt;
      data_r   <= data_nxt;
      abort_r  <= abort_nxt;
    end
  end

  assign frame_ok = hdr_ok_r && ((type_r & ifgp_pkg::TYPE_MASK) == ifgp_pkg::TYPE_MASK) &&
                    (sum_r == byte_in);
  assign last_frame = (int'(fidx_r) + 1) >= ifgp_pkg::FRAMES_PER_GROUP;
  assign close_frame = (phase_r == ifgp_pkg::PH_GROUP) && (pos_r >= ifgp_pkg::CHECK_POS);

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    fidx_nxt   = fidx_r;
    sum_nxt    = sum_r;
    hdr_ok_nxt = hdr_ok_r;
    type_nxt   = type_r;
    data_nxt   = data_r;
    abort_nxt  = abort_r;
    unique case (phase_r)
      ifgp_pkg::PH_HEADER: begin
        if (byte_in == ifgp_pkg::GROUP_TYPE) begin
          phase_nxt  = ifgp_pkg::PH_GROUP;
          pos_nxt    = 4'd2;
          fidx_nxt   = '0;
          sum_nxt    = ifgp_pkg::GROUP_SUM;
          hdr_ok_nxt = 1'b1;
          type_nxt   = ifgp_pkg::GROUP_TYPE;
          data_nxt   = '0;
          abort_nxt  = 1'b0;
        end else begin
          phase_nxt = ifgp_pkg::PH_HUNT;
        end
      end
      ifgp_pkg::PH_GROUP: begin
        if (pos_r == 4'd0) begin
          hdr_ok_nxt = (byte_in == ifgp_pkg::HDR_BYTE);
          sum_nxt    = byte_in;
          data_nxt   = '0;
          pos_nxt    = 4'd1;
        end else if (pos_r < ifgp_pkg::CHECK_POS) begin
          if (pos_r == 4'd1) begin
            type_nxt = byte_in;
          end
          for (int i = 0; i < ifgp_pkg::DATA_LANES; i++) begin
            if (pos_r == 4'(i + 2)) begin
              data_nxt[i*8 +: 8] = byte_in;
            end
          end
          sum_nxt = sum_r + byte_in;
          pos_nxt = pos_r + 4'd1;
        end else begin
          if (!frame_ok) begin
            abort_nxt = 1'b1;
          end
          pos_nxt = 4'd0;
          if (last_frame) begin
            phase_nxt = ifgp_pkg::PH_HUNT;
            fidx_nxt  = '0;
          end else begin
            fidx_nxt = fidx_r + 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = (byte_in == ifgp_pkg::HDR_BYTE) ? ifgp_pkg::PH_HEADER : ifgp_pkg::PH_HUNT;
      end
    endcase
  end

  assign res_push          = byte_vld && close_frame && !abort_r;
  assign res.frame_type    = type_r;
  assign res.axis_x        = data_r[15:0];
  assign res.axis_y        = data_r[31:16];
  assign res.axis_z        = data_r[47:32];
  assign res.frame_status  = !frame_ok;
  assign res.last_of_group = frame_ok ? last_frame : 1'b1;

endmodule

@@ design/ifgp_out_buf.sv @@
// result register with a skid slot behind it
// depends on ifgp_pkg

module ifgp_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ifgp_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output ifgp_pkg::result_t out_data
);

  logic              main_vld_r, main_vld_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  ifgp_pkg::result_t main_r, main_nxt;
  ifgp_pkg::result_t skid_r, skid_nxt;
  logic              pop;

  assign pop = main_vld_r && !out_stall;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (!main_vld_r) begin
      if (push) begin
        main_nxt     = push_data;
        main_vld_nxt = 1'b1;
      end
    end else if (!pop) begin
      if (push) begin
        skid_nxt     = push_data;
        skid_vld_nxt = 1'b1;
      end
    end else if (skid_vld_r) begin
      main_nxt = skid_r;
      if (push) begin
        skid_nxt = push_data;
      end else begin
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      main_nxt = push_data;
    end else begin
      main_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

endmodule

@@ design/imu_frame_group_parser_core.sv @@
// top level of the imu frame group parser: byte parser feeding a result buffer
// depends on ifgp_pkg, ifgp_parser, ifgp_out_buf
//
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  in_rx_byte
// out      output     out_valid/out_stall out_frame_type, out_axis_x/y/z,
//                                        out_frame_status, out_last_of_group
//
// one byte per cycle while in_stall is low; a result is registered into the result
// register, or into the skid slot behind it, when the checksum byte of its frame is taken
// in_stall rises only when the result register and the skid slot both hold items
// synchronous active-low reset returns the parser to header hunting and empties
// the output buffer

module imu_frame_group_parser_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_frame_type,
  output logic signed [15:0] out_axis_x,
  output logic signed [15:0] out_axis_y,
  output logic signed [15:0] out_axis_z,
  output logic               out_frame_status,
  output logic               out_last_of_group
);

  logic              accept;
  logic              res_push;
  logic              buf_full;
  ifgp_pkg::result_t res;
  ifgp_pkg::result_t out_data;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  ifgp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (accept),
    .byte_in  (in_rx_byte),
    .res_push (res_push),
    .res      (res)
  );

  ifgp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_frame_type    = out_data.frame_type;
  assign out_axis_x        = out_data.axis_x;
  assign out_axis_y        = out_data.axis_y;
  assign out_axis_z        = out_data.axis_z;
  assign out_frame_status  = out_data.frame_status;
  assign out_last_of_group = out_data.last_of_group;

endmodule

@@ design/ifgp_checker.sv @@
// port-level checks for the imu frame group parser, bound to the top level
// depends on imu_frame_group_parser_core

module ifgp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [7:0]         out_frame_type,
  input logic signed [15:0] out_axis_x,
  input logic signed [15:0] out_axis_y,
  input logic signed [15:0] out_axis_z,
  input logic               out_frame_status,
  input logic               out_last_of_group
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("outputs not idle after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_type) &&
      $stable(out_axis_x) && $stable(out_axis_y) && $stable(out_axis_z) &&
      $stable(out_frame_status) && $stable(out_last_of_group))
    else $error("stalled result changed");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status |-> out_last_of_group)
    else $error("error result not marked last");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled without a waiting result");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without an accepted item");

endmodule

bind imu_frame_group_parser_core ifgp_checker u_ifgp_checker (.*);
